FILE: hw/rtl/page_framebuffer_rect_fill_defines.svh
// Assertion macros shared by the framebuffer RTL.
// They expect signals named clk and rst_n in the module that uses them.
`ifndef PAGE_FRAMEBUFFER_RECT_FILL_DEFINES_SVH
`define PAGE_FRAMEBUFFER_RECT_FILL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFRF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framebuffer check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define PFRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framebuffer check failed in the following cycle");

`endif

FILE: hw/rtl/pfrf_pkg.sv
`default_nettype none

package pfrf_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = 10;
    localparam int COORD_W     = 8;
    localparam int PAGE_W      = 5;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_READ = 1'b1;
    localparam logic INK_ON  = 1'b1;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [7:0]         byte_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [PAGE_W-1:0]  page_t;

    // Commands from the controller to the address scanner.
    typedef struct packed {
        logic load;
        logic step;
    } scan_ctrl_t;

    // Current byte of the scan and the pixels of it that the rectangle covers.
    typedef struct packed {
        addr_t addr;
        byte_t mask;
        logic  last;
    } scan_out_t;

    // Sets or clears the masked pixels of one stored byte.
    function automatic byte_t apply_ink(byte_t old_byte, byte_t mask, logic ink);
        byte_t result;
        if (ink == INK_ON)
        begin
            result = old_byte | mask;
        end
        else
        begin
            result = old_byte & ~mask;
        end
        return result;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pfrf_store.sv
`default_nettype none

module pfrf_store
    import pfrf_pkg::*;
(
    input  wire logic  clk,
    input  wire addr_t rd_addr,
    output byte_t      rd_data,
    input  wire logic  wr_en,
    input  wire addr_t wr_addr,
    input  wire byte_t wr_data
);

    // One write port and one read port, read data registered.
    byte_t mem [STORE_DEPTH];
    byte_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/pfrf_scan.sv
`default_nettype none

module pfrf_scan
    import pfrf_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire scan_ctrl_t ctrl,
    input  wire coord_t     left,
    input  wire coord_t     top,
    input  wire coord_t     span_w,
    input  wire coord_t     span_h,
    output scan_out_t       scan
);

    localparam int NUM_PAGES  = (SCREEN_HEIGHT + 7) / 8;
    localparam int SCAN_BYTES = SCREEN_WIDTH * NUM_PAGES;
    localparam int LAST_ADDR  = ((SCAN_BYTES < STORE_DEPTH) ? SCAN_BYTES : STORE_DEPTH) - 1;

    coord_t col_reg,  col_next;
    page_t  page_reg, page_next;
    addr_t  addr_reg, addr_next;
    coord_t left_reg, top_reg, span_w_reg, span_h_reg;

    logic   col_hit;
    byte_t  row_hits;

    always_comb
    begin
        col_next  = col_reg;
        page_next = page_reg;
        addr_next = addr_reg;
        if (ctrl.load)
        begin
            col_next  = '0;
            page_next = '0;
            addr_next = '0;
        end
        else if (ctrl.step)
        begin
            addr_next = addr_reg + ADDR_W'(1);
            if (col_reg == COORD_W'(SCREEN_WIDTH - 1))
            begin
                col_next  = '0;
                page_next = page_reg + PAGE_W'(1);
            end
            else
            begin
                col_next = col_reg + COORD_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            page_reg <= '0;
            addr_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            page_reg <= page_next;
            addr_reg <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            left_reg   <= left;
            top_reg    <= top;
            span_w_reg <= span_w;
            span_h_reg <= span_h;
        end
    end

    // Membership is tested on the offset from the corner modulo 256, which
    // covers rectangles that wrap past coordinate 255.
    always_comb
    begin
        coord_t col_off;
        coord_t row;
        coord_t row_off;
        col_off = col_reg - left_reg;
        col_hit = (col_off < span_w_reg);
        for (int b = 0; b < 8; b++)
        begin
            row         = {page_reg, 3'(b)};
            row_off     = row - top_reg;
            row_hits[b] = ({1'b0, row} < 9'(SCREEN_HEIGHT)) && (row_off < span_h_reg);
        end
    end

    assign scan.addr = addr_reg;
    assign scan.mask = col_hit ? row_hits : 8'h00;
    assign scan.last = (addr_reg == ADDR_W'(LAST_ADDR));

endmodule

`default_nettype wire

FILE: hw/rtl/page_framebuffer_rect_fill.sv
`default_nettype none

// Monochrome page-organised framebuffer with a rectangle fill engine. Each
// stored byte holds eight vertical pixels of one column, bit 0 at the top,
// at address x + (y / 8) * SCREEN_WIDTH. A word is taken when start is high
// and busy is low. A draw word sets (ink high) or clears every on-screen
// pixel of a span_w by span_h rectangle at (left, top), coordinates wrapping
// modulo 256; a read word returns the byte at byte_index. Every word gives
// exactly one result, shown for a single cycle with done high; the receiver
// cannot stall it, so it must capture read_byte and is_read on that cycle.
// A draw reports read_byte as zero and is_read low.
//
// After reset the store is cleared by a pass over all 1024 bytes with busy
// high. A read word passes the registered store read and ST_READ before
// done, and the next word may be accepted while done is high. A draw with
// zero width or height gives done in the next cycle and busy stays low. Any
// other draw scans every store byte of the screen, N = min(SCREEN_WIDTH *
// ceil(SCREEN_HEIGHT / 8), 1024) bytes (1024 by default), as one
// read-modify-write per cycle through the single store port pair; done
// is registered in ST_DRAIN; the next word may be taken with done high.

module page_framebuffer_rect_fill
    import pfrf_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       operation,
    input  wire logic [7:0] left,
    input  wire logic [7:0] top,
    input  wire logic [7:0] span_w,
    input  wire logic [7:0] span_h,
    input  wire logic       ink,
    input  wire logic [9:0] byte_index,
    output logic            done,
    output logic [7:0]      read_byte,
    output logic            is_read
);

`include "page_framebuffer_rect_fill_defines.svh"

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_DRAIN = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    addr_t      clr_addr_reg, clr_addr_next;
    logic       done_reg, done_next;
    byte_t      read_byte_reg, read_byte_next;
    logic       is_read_reg, is_read_next;
    logic       ink_reg;

    // Stage between the store read and the write back.
    logic       s1_valid_reg;
    addr_t      s1_addr_reg;
    byte_t      s1_mask_reg;

    scan_ctrl_t scan_ctrl;
    scan_out_t  scan;
    addr_t      rd_addr;
    byte_t      rd_data;
    logic       wr_en;
    addr_t      wr_addr;
    byte_t      wr_data;
    logic       clearing;

    pfrf_scan #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (scan_ctrl),
        .left   (left),
        .top    (top),
        .span_w (span_w),
        .span_h (span_h),
        .scan   (scan)
    );

    pfrf_store u_store (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Controller. Only one word is in flight at a time; during a draw the
    // scan addresses are all distinct, so a byte read in one cycle is never
    // the one being written back in the same cycle.
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        done_next      = 1'b0;
        read_byte_next = 8'h00;
        is_read_next   = 1'b0;
        scan_ctrl.load = 1'b0;
        scan_ctrl.step = 1'b0;
        rd_addr        = scan.addr;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                rd_addr = byte_index;
                if (start)
                begin
                    if (operation == OP_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else if (span_w == 8'h00 || span_h == 8'h00)
                    begin
                        // Nothing to draw: report straight away.
                        done_next = 1'b1;
                    end
                    else
                    begin
                        scan_ctrl.load = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_READ:
            begin
                done_next      = 1'b1;
                read_byte_next = rd_data;
                is_read_next   = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_SCAN:
            begin
                scan_ctrl.step = 1'b1;
                if (scan.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // The last byte of the scan is written back in this cycle.
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
            s1_valid_reg <= (state_reg == ST_SCAN);
        end
    end

    always_ff @(posedge clk)
    begin
        read_byte_reg <= read_byte_next;
        is_read_reg   <= is_read_next;
        s1_addr_reg   <= scan.addr;
        s1_mask_reg   <= scan.mask;
        if (scan_ctrl.load)
        begin
            ink_reg <= ink;
        end
    end

    // Write port: the clearing pass after reset, otherwise the write back of
    // the byte read in the previous cycle.
    assign clearing = (state_reg == ST_CLEAR);
    assign wr_en    = clearing || s1_valid_reg;
    assign wr_addr  = clearing ? clr_addr_reg : s1_addr_reg;
    assign wr_data  = clearing ? 8'h00 : apply_ink(rd_data, s1_mask_reg, ink_reg);

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign read_byte = read_byte_reg;
    assign is_read   = is_read_reg;

    // A read that is accepted keeps the block busy while the store answers.
    `PFRF_ASSERT_NEXT(a_read_holds_busy, start && !busy && operation == OP_READ, busy)
    // The cycle after the store answers a read, the result is presented.
    `PFRF_ASSERT_NEXT(a_read_result, state_reg == ST_READ, done && is_read)
    // The end of a scan is reported as a draw result with a zero byte.
    `PFRF_ASSERT_NEXT(a_draw_result, state_reg == ST_DRAIN,
                      done && !is_read && read_byte == 8'h00)
    // No result can appear while the store is still being cleared.
    `PFRF_ASSERT_SAME(a_clear_quiet, clearing, busy && !done && !s1_valid_reg)

endmodule

`default_nettype wire
